[src/rbe_pkg.sv]
package rbe_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int RETURN_BITS = 16;
  localparam int SLOT_W      = $clog2(WINDOW_MAX);
  localparam int WLEN_W      = 9;
  localparam int WLEN_MIN    = 2;
  localparam int WLEN_RESET  = 60;
  localparam int PROD_W      = 2 * RETURN_BITS;
  localparam int SUM_W       = RETURN_BITS + SLOT_W;
  localparam int SQ_W        = PROD_W + SLOT_W;
  localparam int PAIR_W      = 2 * SUM_W;
  localparam int NUM_W       = WLEN_W + 1 + SQ_W;
  localparam int BETA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIV_STEPS   = BETA_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  localparam logic [BETA_W-1:0] BETA_MAX = {1'b0, {(BETA_W-1){1'b1}}};
  localparam logic [BETA_W-1:0] BETA_MIN = {1'b1, {(BETA_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic prod;
    logic update;
    logic mul;
    logic sub;
    logic absval;
    logic check;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic den_zero;
    logic sat;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

[src/rbe_ctrl.sv]
module rbe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbe_pkg::status_t  status,
  output rbe_pkg::cmd_t     cmd
);
  import rbe_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PROD = 9'b000000010,
    S_UPD  = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_SUB  = 9'b000010000,
    S_ABS  = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.emit ? S_SUB : S_IDLE;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.absval = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.check  = 1'b1;
        state_next = (status.den_zero || status.sat) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_load_to_prod: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_PROD) else $error("item load did not start products");
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && !status.div_last |=> state == S_DIV)
    else $error("divider left early");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE) else $error("no return to idle after result");
`endif

endmodule

[src/rbe_dp.sv]
module rbe_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [rbe_pkg::WLEN_W-1:0]             cfg_wr_data,
  input  logic signed [rbe_pkg::RETURN_BITS-1:0] asset_return,
  input  logic signed [rbe_pkg::RETURN_BITS-1:0] benchmark_return,
  input  logic                                   first_of_series,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [rbe_pkg::BETA_W-1:0]      beta,
  output logic                                   zero_variance,
  input  rbe_pkg::cmd_t                          cmd,
  output rbe_pkg::status_t                       status
);
  import rbe_pkg::*;

  logic [WLEN_W-1:0]               w_eff;
  logic [WLEN_W-1:0]               wlen_clamped;
  logic [WLEN_W-1:0]               fill_count;
  logic [WLEN_W-1:0]               fill_inc;
  logic [SLOT_W-1:0]               write_slot;
  logic [SLOT_W-1:0]               old_slot;
  logic [PROD_W-1:0]               win_mem [WINDOW_MAX];
  logic [PROD_W-1:0]               rd_data;
  logic signed [RETURN_BITS-1:0]   a_in;
  logic signed [RETURN_BITS-1:0]   b_in;
  logic signed [RETURN_BITS-1:0]   a_old;
  logic signed [RETURN_BITS-1:0]   b_old;
  logic signed [PROD_W-1:0]        p_ab;
  logic signed [PROD_W-1:0]        p_bb;
  logic signed [PROD_W-1:0]        o_ab;
  logic signed [PROD_W-1:0]        o_bb;
  logic signed [SUM_W-1:0]         sum_asset;
  logic signed [SUM_W-1:0]         sum_bench;
  logic signed [SQ_W-1:0]          sum_cross;
  logic signed [SQ_W-1:0]          sum_bench_sq;
  logic                            evict;
  logic                            emit;
  logic signed [WLEN_W:0]          w_s;
  logic signed [NUM_W-1:0]         m_wab;
  logic signed [NUM_W-1:0]         m_wbb;
  logic signed [PAIR_W-1:0]        m_ab;
  logic signed [PAIR_W-1:0]        m_bb;
  logic signed [NUM_W-1:0]         num;
  logic signed [NUM_W-1:0]         den;
  logic [NUM_W-1:0]                mag;
  logic                            neg;
  logic [NUM_W-1:0]                rem;
  logic [BETA_W-1:0]               quo;
  logic [BETA_W-1:0]               quo_neg;
  logic [CNT_W-1:0]                cnt;
  logic                            den_zero;
  logic                            sat;
  logic                            zero_flag;
  logic                            sat_flag;
  logic [NUM_W+FRAC_BITS-1:0]      den_shift;
  logic [NUM_W+FRAC_BITS-1:0]      mag_wide;
  logic [NUM_W:0]                  trial;
  logic [NUM_W:0]                  den_ext;
  logic                            trial_ge;
  logic [BETA_W-1:0]               beta_val;

  // config clamp
  always_comb begin
    if (cfg_wr_data < WLEN_W'(WLEN_MIN)) begin
      wlen_clamped = WLEN_W'(WLEN_MIN);
    end else if (cfg_wr_data > WLEN_W'(WINDOW_MAX)) begin
      wlen_clamped = WLEN_W'(WINDOW_MAX);
    end else begin
      wlen_clamped = cfg_wr_data;
    end
  end

  assign old_slot = write_slot - w_eff[SLOT_W-1:0];
  assign fill_inc = fill_count + WLEN_W'(1);
  assign evict    = fill_count >= w_eff;
  assign a_old    = rd_data[PROD_W-1:RETURN_BITS];
  assign b_old    = rd_data[RETURN_BITS-1:0];
  assign w_s      = {1'b0, w_eff};

  // window store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= win_mem[old_slot];
    end
    if (cmd.update) begin
      win_mem[write_slot] <= {a_in, b_in};
    end
  end

  // series state and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff        <= WLEN_W'(WLEN_RESET);
      fill_count   <= '0;
      write_slot   <= '0;
      sum_asset    <= '0;
      sum_bench    <= '0;
      sum_cross    <= '0;
      sum_bench_sq <= '0;
      emit         <= 1'b0;
    end else if (cfg_wr_en) begin
      w_eff        <= wlen_clamped;
      fill_count   <= '0;
      sum_asset    <= '0;
      sum_bench    <= '0;
      sum_cross    <= '0;
      sum_bench_sq <= '0;
    end else if (cmd.load && first_of_series) begin
      fill_count   <= '0;
      sum_asset    <= '0;
      sum_bench    <= '0;
      sum_cross    <= '0;
      sum_bench_sq <= '0;
    end else if (cmd.update) begin
      sum_asset    <= sum_asset + SUM_W'(a_in) - (evict ? SUM_W'(a_old) : SUM_W'(0));
      sum_bench    <= sum_bench + SUM_W'(b_in) - (evict ? SUM_W'(b_old) : SUM_W'(0));
      sum_cross    <= sum_cross + SQ_W'(p_ab) - (evict ? SQ_W'(o_ab) : SQ_W'(0));
      sum_bench_sq <= sum_bench_sq + SQ_W'(p_bb) - (evict ? SQ_W'(o_bb) : SQ_W'(0));
      fill_count   <= evict ? w_eff : fill_inc;
      emit         <= evict || (fill_inc >= w_eff);
      write_slot   <= write_slot + SLOT_W'(1);
    end
  end

  // item capture and arithmetic chain
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_in <= asset_return;
      b_in <= benchmark_return;
    end
    if (cmd.prod) begin
      p_ab <= PROD_W'(a_in) * PROD_W'(b_in);
      p_bb <= PROD_W'(b_in) * PROD_W'(b_in);
      o_ab <= PROD_W'(a_old) * PROD_W'(b_old);
      o_bb <= PROD_W'(b_old) * PROD_W'(b_old);
    end
    if (cmd.mul) begin
      m_wab <= NUM_W'(w_s) * NUM_W'(sum_cross);
      m_wbb <= NUM_W'(w_s) * NUM_W'(sum_bench_sq);
      m_ab  <= PAIR_W'(sum_asset) * PAIR_W'(sum_bench);
      m_bb  <= PAIR_W'(sum_bench) * PAIR_W'(sum_bench);
    end
    if (cmd.sub) begin
      num <= m_wab - NUM_W'(m_ab);
      den <= m_wbb - NUM_W'(m_bb);
    end
    if (cmd.absval) begin
      neg <= num[NUM_W-1];
      mag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    end
  end

  // divide checks
  assign den_zero  = (den == '0) || den[NUM_W-1];
  assign den_shift = {den, {FRAC_BITS{1'b0}}};
  assign mag_wide  = {{FRAC_BITS{1'b0}}, mag};
  assign sat       = mag_wide >= den_shift;

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, quo[BETA_W-1]};
  assign den_ext  = {1'b0, den};
  assign trial_ge = trial >= den_ext;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      zero_flag <= den_zero;
      sat_flag  <= sat;
      rem       <= mag >> FRAC_BITS;
      quo       <= {mag[FRAC_BITS-1:0], {(BETA_W-FRAC_BITS){1'b0}}};
      cnt       <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? NUM_W'(trial - den_ext) : NUM_W'(trial);
      quo <= {quo[BETA_W-2:0], trial_ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // sign and saturation
  assign quo_neg = ~quo + BETA_W'(1);

  always_comb begin
    if (zero_flag) begin
      beta_val = '0;
    end else if (!neg) begin
      beta_val = (sat_flag || quo[BETA_W-1]) ? BETA_MAX : quo;
    end else begin
      beta_val = (sat_flag || (quo > BETA_MIN)) ? BETA_MIN : quo_neg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      beta          <= beta_val;
      zero_variance <= zero_flag;
    end
  end

  assign status.emit     = emit;
  assign status.den_zero = den_zero;
  assign status.sat      = sat;
  assign status.div_last = cnt == CNT_W'(DIV_STEPS - 1);
  assign status.out_free = !out_valid || out_ready;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= w_eff) else $error("fill count above window length");
  a_wlen_range: assert property (@(posedge clk) disable iff (rst)
    (w_eff >= WLEN_W'(WLEN_MIN)) && (w_eff <= WLEN_W'(WINDOW_MAX)))
    else $error("window length out of range");
  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    cmd.mul && emit |-> fill_count == w_eff) else $error("result from partial window");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < $unsigned(den)) else $error("divider remainder not reduced");
  a_zero_beta: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_variance |-> beta == '0) else $error("nonzero beta with zero variance");
`endif

endmodule

[src/rolling_beta_estimator_unit.sv]
// one item at a time: a new item is taken only in idle, once the last is done;
// with the window not yet full no result is made. The restoring divider is skipped
// when the benchmark variance is zero or beta saturates, else it sets the rate; a
// finished result waits until the output register is free.
// reset: window length 60, sums, fill count and write slot cleared, no result pending
module rolling_beta_estimator_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [rbe_pkg::WLEN_W-1:0]             cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rbe_pkg::RETURN_BITS-1:0] asset_return,
  input  logic signed [rbe_pkg::RETURN_BITS-1:0] benchmark_return,
  input  logic                                   first_of_series,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rbe_pkg::BETA_W-1:0]      beta,
  output logic                                   zero_variance
);
  import rbe_pkg::*;

  cmd_t    cmd;
  status_t status;

  rbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rbe_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .asset_return     (asset_return),
    .benchmark_return (benchmark_return),
    .first_of_series  (first_of_series),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .beta             (beta),
    .zero_variance    (zero_variance),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
